FILE: rtl/grc_pkg.sv
// grc_pkg: shared types and constants of the grid ray caster
// used by the controller, the datapath and the top level
package grc_pkg;

  localparam int NUM_W  = 32;
  localparam int DEN_W  = 48;
  localparam int ACC_W  = 47;
  localparam int DEL_W  = 41;
  localparam int RAY_W  = 26;
  localparam int CAM_W  = 22;
  localparam int CELL_W = 8;
  localparam int STEP_LIMIT = 32;

  localparam logic [23:0] COLOR_RED   = 24'hFF0000;
  localparam logic [23:0] COLOR_GREEN = 24'h00FF00;
  localparam logic [23:0] COLOR_BLUE  = 24'h0000FF;
  localparam logic [23:0] COLOR_WHITE = 24'hFFFFFF;

  localparam logic [3:0] KIND_RED   = 4'd1;
  localparam logic [3:0] KIND_GREEN = 4'd2;
  localparam logic [3:0] KIND_BLUE  = 4'd3;
  localparam logic [3:0] KIND_WHITE = 4'd4;

  typedef enum logic [3:0] {
    OP_NONE, OP_LOAD, OP_CAM, OP_RAY, OP_DELX, OP_DELY, OP_INIT, OP_STEP, OP_HGT, OP_FIN
  } op_t;

  typedef struct packed {
    op_t op;
  } cmd_t;

  typedef struct packed {
    logic div_done;
    logic walk_done;
  } status_t;

  function automatic logic [23:0] kind_color(input logic [3:0] k);
    logic [23:0] c;
    case (k)
      KIND_RED:   c = COLOR_RED;
      KIND_GREEN: c = COLOR_GREEN;
      KIND_BLUE:  c = COLOR_BLUE;
      KIND_WHITE: c = COLOR_WHITE;
      default:    c = 24'd0;
    endcase
    return c;
  endfunction

endpackage

FILE: rtl/grid_ray_caster_column.sv
// sequence per column: load, camera, ray, two divider passes for the x and y deltas,
// init, one dda step per cycle (1 to 32 steps), a divider pass for the height and
// the result; each divider pass issues, shifts in 32 quotient bits and signals done
// flow: input held off while busy; a new column is taken while the last result waits,
// the next result waits for m_tready
// reset: synchronous active-high rst clears the controller, output valid and the map
module grid_ray_caster_column import grc_pkg::*; #(
  parameter int MAP_DIM = 8,
  parameter int SCREEN_COLUMNS = 384,
  parameter int SCREEN_ROWS = 216
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  // column, pos_x, pos_y, dir_x, dir_y, plane_x, plane_y, zero pad
  input  logic [103:0] s_tdata,
  output logic         m_tvalid,
  input  logic         m_tready,
  // out_column, draw_start, draw_end, wall_color, hit_side, wall_kind,
  // wall_distance, off_map, zero pad
  output logic [71:0]  m_tdata,
  input  logic         cfg_we,
  input  logic [1:0]   cfg_index,
  input  logic [63:0]  cfg_data
);
  cmd_t    cmd;
  status_t status;

  // sequencer: one column at a time
  grc_ctrl u_ctrl (
    .clk(clk), .rst(rst),
    .in_valid(s_tvalid), .in_ready(s_tready),
    .out_valid(m_tvalid), .out_ready(m_tready),
    .cmd(cmd), .status(status)
  );

  // arithmetic, map storage and result register
  grc_datapath #(
    .MAP_DIM(MAP_DIM), .SCREEN_COLUMNS(SCREEN_COLUMNS), .SCREEN_ROWS(SCREEN_ROWS)
  ) u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .status(status),
    .in_data(s_tdata),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .out_data(m_tdata)
  );
endmodule

FILE: rtl/grc_div.sv
// grc_div: restoring divider, one quotient bit per cycle
// depends on grc_pkg for operand widths
module grc_div import grc_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic             done,
  output logic [NUM_W-1:0] quo
);
  logic [NUM_W-1:0] q;
  logic [DEN_W:0]   rem;
  logic [DEN_W-1:0] dvs;
  logic [5:0]       cnt;
  logic             run;
  logic [DEN_W:0]   rem_sh;
  logic             fits;

  assign rem_sh = {rem[DEN_W-1:0], q[NUM_W-1]};
  assign fits   = rem_sh >= {1'b0, dvs};
  assign quo    = q;

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        run <= 1'b1;
        cnt <= '0;
      end else if (run) begin
        cnt <= cnt + 6'd1;
        if (cnt == 6'(NUM_W - 1)) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      q   <= num;
      rem <= '0;
      dvs <= den;
    end else if (run) begin
      rem <= fits ? rem_sh - {1'b0, dvs} : rem_sh;
      q   <= {q[NUM_W-2:0], fits};
    end
  end
endmodule

FILE: rtl/grc_datapath.sv
// grc_datapath: camera, ray, dda walk, height and result registers
// depends on grc_pkg and grc_div
module grc_datapath import grc_pkg::*; #(
  parameter int MAP_DIM = 8,
  parameter int SCREEN_COLUMNS = 384,
  parameter int SCREEN_ROWS = 216
) (
  input  logic         clk,
  input  logic         rst,
  input  cmd_t         cmd,
  output status_t      status,
  input  logic [103:0] in_data,
  input  logic         cfg_we,
  input  logic [1:0]   cfg_index,
  input  logic [63:0]  cfg_data,
  output logic [71:0]  out_data
);
  localparam logic [31:0] HMAX      = 32'(SCREEN_ROWS * 4);
  localparam logic [31:0] HALF_ROWS = 32'(SCREEN_ROWS / 2);
  localparam logic [31:0] LAST_ROW  = 32'(SCREEN_ROWS - 1);
  localparam logic [31:0] ROWS_NUM  = 32'(SCREEN_ROWS * 65536);
  localparam logic [CELL_W-1:0] DIM = CELL_W'(MAP_DIM);
  localparam logic signed [CELL_W-1:0] CELL_ONE = CELL_W'(1);
  // ceil(2^35 / columns): exact floor(col * 2^15 / columns) for 9-bit columns
  localparam longint unsigned CAM_RECIP_FULL =
    ((64'd1 << 35) + 64'(SCREEN_COLUMNS) - 64'd1) / 64'(SCREEN_COLUMNS);
  localparam logic [31:0] CAM_RECIP = 32'(CAM_RECIP_FULL);

  logic [3:0][63:0] maps;
  logic [8:0]  col;
  logic [14:0] px, py;
  logic signed [15:0] dx, dy, plx, ply;
  logic signed [CAM_W-1:0] cam;
  logic neg_x, neg_y;
  logic [RAY_W-1:0] ax, ay;
  logic [DEL_W-1:0] delx, dely;
  logic [ACC_W-1:0] accx, accy;
  logic signed [CELL_W-1:0] cx, cy;
  logic [4:0] n;
  logic side, off;
  logic [3:0] kind;
  op_t div_op;

  logic div_start, div_done;
  logic [NUM_W-1:0] div_num, quo;
  logic [DEN_W-1:0] div_den;

  grc_div u_div (
    .clk(clk), .rst(rst), .start(div_start), .num(div_num), .den(div_den),
    .done(div_done), .quo(quo)
  );

  // camera by reciprocal multiply
  logic [40:0] cam_prod;
  assign cam_prod = col * CAM_RECIP;

  // ray
  logic signed [37:0] prodx, prody;
  logic signed [RAY_W-1:0] rx, ry;
  assign prodx = plx * cam;
  assign prody = ply * cam;
  assign rx = RAY_W'(dx) + RAY_W'(prodx >>> 14);
  assign ry = RAY_W'(dy) + RAY_W'(prody >>> 14);

  // initial side distances
  logic [12:0] fx, fy;
  logic [43:0] mx, my;
  assign fx = neg_x ? {1'b0, px[11:0]} : 13'd4096 - {1'b0, px[11:0]};
  assign fy = neg_y ? {1'b0, py[11:0]} : 13'd4096 - {1'b0, py[11:0]};
  assign mx = fx * delx[30:0];
  assign my = fy * dely[30:0];

  // one dda step
  logic stepx, outside, hit;
  logic signed [CELL_W-1:0] nx, ny;
  logic [3:0] map_kind;
  assign stepx = accx < accy;
  assign nx = stepx ? (neg_x ? cx - CELL_ONE : cx + CELL_ONE) : cx;
  assign ny = stepx ? cy : (neg_y ? cy - CELL_ONE : cy + CELL_ONE);
  assign outside = nx < 0 || ny < 0 || nx >= $signed(DIM) || ny >= $signed(DIM);
  assign map_kind = maps[ny[2:1]][{ny[0], nx[2:0], 2'b00} +: 4];
  assign hit = !outside && map_kind != 4'd0;

  assign status.div_done  = div_done;
  assign status.walk_done = outside || hit || n == 5'(STEP_LIMIT - 1);

  // final distance and span
  logic [ACC_W-1:0] perp_dist;
  logic [31:0] h, half, sum;
  assign perp_dist = side ? accy - ACC_W'(dely) : accx - ACC_W'(delx);
  assign h    = (quo > HMAX) ? HMAX : quo;
  assign half = h >> 1;
  assign sum  = HALF_ROWS + half;

  always_comb begin
    div_start = 1'b0;
    div_num   = '0;
    div_den   = '0;
    case (cmd.op)
      OP_DELX: begin
        div_start = 1'b1;
        div_num   = 32'h4000_0000;
        div_den   = DEN_W'(ax);
      end
      OP_DELY: begin
        div_start = 1'b1;
        div_num   = 32'h4000_0000;
        div_den   = DEN_W'(ay);
      end
      OP_HGT: begin
        div_start = 1'b1;
        div_num   = ROWS_NUM;
        div_den   = DEN_W'(perp_dist);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      maps <= '0;
    end else if (cfg_we) begin
      maps[cfg_index] <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (div_start) div_op <= cmd.op;
    if (div_done) begin
      case (div_op)
        OP_DELX: delx <= (ax == '0) ? DEL_W'(1) << 40 : DEL_W'(quo);
        OP_DELY: dely <= (ay == '0) ? DEL_W'(1) << 40 : DEL_W'(quo);
        default: ;
      endcase
    end
    case (cmd.op)
      OP_LOAD: begin
        col <= in_data[8:0];
        px  <= in_data[23:9];
        py  <= in_data[38:24];
        dx  <= in_data[54:39];
        dy  <= in_data[70:55];
        plx <= in_data[86:71];
        ply <= in_data[102:87];
      end
      OP_CAM: begin
        cam <= $signed({1'b0, cam_prod[40:20]}) - CAM_W'(16384);
      end
      OP_RAY: begin
        neg_x <= rx < 0;
        neg_y <= ry < 0;
        ax    <= rx < 0 ? -rx : rx;
        ay    <= ry < 0 ? -ry : ry;
      end
      OP_INIT: begin
        accx <= (ax == '0) ? ACC_W'({fx, 28'd0}) : ACC_W'(mx >> 12);
        accy <= (ay == '0) ? ACC_W'({fy, 28'd0}) : ACC_W'(my >> 12);
        cx   <= CELL_W'(px[14:12]);
        cy   <= CELL_W'(py[14:12]);
        n    <= '0;
        off  <= 1'b1;
        kind <= '0;
        side <= 1'b0;
      end
      OP_STEP: begin
        if (stepx) accx <= accx + ACC_W'(delx);
        else       accy <= accy + ACC_W'(dely);
        side <= !stepx;
        cx   <= nx;
        cy   <= ny;
        n    <= n + 5'd1;
        if (!outside) kind <= map_kind;
        if (hit) off <= 1'b0;
      end
      OP_FIN: begin
        out_data[8:0] <= col;
        out_data[49]  <= side;
        out_data[70]  <= off;
        out_data[71]  <= 1'b0;
        if (off) begin
          out_data[16:9]  <= HALF_ROWS[7:0];
          out_data[24:17] <= HALF_ROWS[7:0];
          out_data[48:25] <= '0;
          out_data[53:50] <= '0;
          out_data[69:54] <= 16'hFFFF;
        end else begin
          out_data[16:9]  <= (half >= HALF_ROWS) ? 8'd0 : 8'(HALF_ROWS - half);
          out_data[24:17] <= (sum > LAST_ROW) ? LAST_ROW[7:0] : sum[7:0];
          out_data[48:25] <= kind_color(kind);
          out_data[53:50] <= kind;
          out_data[69:54] <= ((perp_dist >> 4) > ACC_W'(16'hFFFF)) ? 16'hFFFF :
                             perp_dist[19:4];
        end
      end
      default: ;
    endcase
  end
endmodule

FILE: rtl/grc_ctrl.sv
// grc_ctrl: sequencer for one column, issues datapath operations
// depends on grc_pkg
module grc_ctrl import grc_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    in_valid,
  output logic    in_ready,
  output logic    out_valid,
  input  logic    out_ready,
  output cmd_t    cmd,
  input  status_t status
);
  typedef enum logic [11:0] {
    S_IDLE  = 12'b000000000001,
    S_CAMI  = 12'b000000000010,
    S_RAY   = 12'b000000000100,
    S_DXI   = 12'b000000001000,
    S_DXW   = 12'b000000010000,
    S_DYI   = 12'b000000100000,
    S_DYW   = 12'b000001000000,
    S_INIT  = 12'b000010000000,
    S_STEP  = 12'b000100000000,
    S_HGTI  = 12'b001000000000,
    S_HGTW  = 12'b010000000000,
    S_FIN   = 12'b100000000000
  } state_t;

  state_t state, state_next;
  logic   fin_ok;

  assign in_ready = state == S_IDLE;
  assign fin_ok   = !out_valid || out_ready;

  always_comb begin
    state_next = state;
    cmd.op     = OP_NONE;
    case (state)
      S_IDLE: if (in_valid) begin cmd.op = OP_LOAD; state_next = S_CAMI; end
      S_CAMI: begin cmd.op = OP_CAM; state_next = S_RAY; end
      S_RAY:  begin cmd.op = OP_RAY; state_next = S_DXI; end
      S_DXI:  begin cmd.op = OP_DELX; state_next = S_DXW; end
      S_DXW:  if (status.div_done) state_next = S_DYI;
      S_DYI:  begin cmd.op = OP_DELY; state_next = S_DYW; end
      S_DYW:  if (status.div_done) state_next = S_INIT;
      S_INIT: begin cmd.op = OP_INIT; state_next = S_STEP; end
      S_STEP: begin
        cmd.op = OP_STEP;
        if (status.walk_done) state_next = S_HGTI;
      end
      S_HGTI: begin cmd.op = OP_HGT; state_next = S_HGTW; end
      S_HGTW: if (status.div_done) state_next = S_FIN;
      S_FIN:  if (fin_ok) begin cmd.op = OP_FIN; state_next = S_IDLE; end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == S_FIN && fin_ok) out_valid <= 1'b1;
      else if (out_ready)           out_valid <= 1'b0;
    end
  end
endmodule

FILE: rtl/grc_checker.sv
// grc_checker: port-level assertions for the ray caster
// bound to grid_ray_caster_column, no package needed
module grc_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [71:0] m_tdata
);
  // a stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata)) else $error("result changed");
  // busy after a transaction is taken
  a_busy: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready) else $error("accepted twice");
  // no result right after reset
  a_rst: assert property (@(posedge clk) rst |=> !m_tvalid) else $error("valid after reset");
  // off-map results carry no wall
  a_off: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[70] |-> m_tdata[53:50] == 4'd0 && m_tdata[48:25] == 24'd0
    && m_tdata[69:54] == 16'hFFFF) else $error("off-map result inconsistent");
endmodule

bind grid_ray_caster_column grc_checker u_grc_checker (
  .clk(clk), .rst(rst), .s_tvalid(s_tvalid), .s_tready(s_tready),
  .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
);

FILE: bench/grid_ray_caster_column_tb.sv
// grid_ray_caster_column_tb: self-checking bench for the dda column ray caster
// depends on grc_pkg and grid_ray_caster_column; predicts every column in-line
`timescale 1ns / 100ps

module grid_ray_caster_column_tb;
  import grc_pkg::*;

  localparam int COLS = 384;
  localparam int ROWS = 216;
  localparam int DIM = 8;
  localparam int DRAIN_CYCLES = 250;   // above the block's worst latency
  localparam int CYCLE_LIMIT = 1500000;
  localparam int RANDOM_ITEMS = 750;

  // register indexes of the map rows
  localparam logic [1:0] REG_ROWS_A = 2'd0;
  localparam logic [1:0] REG_ROWS_B = 2'd1;
  localparam logic [1:0] REG_ROWS_C = 2'd2;
  localparam logic [1:0] REG_ROWS_D = 2'd3;

  typedef struct {
    logic [8:0]         column;
    logic [14:0]        pos_x;
    logic [14:0]        pos_y;
    logic signed [15:0] dir_x;
    logic signed [15:0] dir_y;
    logic signed [15:0] plane_x;
    logic signed [15:0] plane_y;
  } column_req_t;

  typedef struct {
    logic [8:0]  out_column;
    logic [7:0]  draw_start;
    logic [7:0]  draw_end;
    logic [23:0] wall_color;
    logic        hit_side;
    logic [3:0]  wall_kind;
    logic [15:0] wall_distance;
    logic        off_map;
  } wall_hit_t;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         s_tvalid = 1'b0;
  logic         s_tready;
  logic [103:0] s_tdata = '0;   // column, pos_x, pos_y, dir_x, dir_y, plane_x, plane_y, pad
  logic         m_tvalid;
  logic         m_tready = 1'b0;
  logic [71:0]  m_tdata;        // out_column, draw_start, draw_end, wall_color, hit_side,
                                // wall_kind, wall_distance, off_map, pad
  logic         cfg_we = 1'b0;
  logic [1:0]   cfg_index = '0;
  logic [63:0]  cfg_data = '0;

  grid_ray_caster_column dut (.*);

  always #2 clk = ~clk;

  // shadow of the map registers used by the predictor
  logic [63:0] map_shadow [4];
  column_req_t pending_columns[$];
  wall_hit_t   expected_hits[$];
  int          errors = 0;
  int          hits_checked = 0;
  int          off_map_seen = 0;
  int          cycles = 0;
  logic        took = 1'b0;       // input transaction at the last rising edge
  int          send_gap = 0;
  int          recv_gap = 0;
  logic        calm = 1'b0;       // phases with no idling at all

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 55) return 0;
    if (r < 92) return $urandom_range(1, 4);
    return $urandom_range(10, 60);
  endfunction

  function automatic logic [103:0] pack_column(column_req_t c);
    return {1'b0, c.plane_y, c.plane_x, c.dir_y, c.dir_x, c.pos_y, c.pos_x, c.column};
  endfunction

  function automatic column_req_t unpack_column(logic [103:0] d);
    column_req_t c;
    {c.plane_y, c.plane_x, c.dir_y, c.dir_x, c.pos_y, c.pos_x, c.column} = d[102:0];
    return c;
  endfunction

  function automatic logic [3:0] map_cell(longint x, longint y);
    return map_shadow[(y >> 1) & 3][((y & 1) * 8 + x) * 4 +: 4];
  endfunction

  // dda walk in 64-bit integers, same fixed-point steps as the block
  function automatic wall_hit_t cast_column(column_req_t c);
    wall_hit_t h;
    longint cam, rx, ry, cx, cy, sx, sy, s, e;
    longint unsigned ax, ay, dlx, dly, fx, fy, accx, accy, perp_dist, height, wd;
    logic [3:0] kind;
    logic side, off;
    cam = longint'((longint'(c.column) << 15) / COLS) - 16384;
    rx = longint'(c.dir_x) + ((longint'(c.plane_x) * cam) >>> 14);
    ry = longint'(c.dir_y) + ((longint'(c.plane_y) * cam) >>> 14);
    ax = rx < 0 ? -rx : rx;
    ay = ry < 0 ? -ry : ry;
    dlx = ax != 0 ? (64'd1 << 30) / ax : 64'd1 << 40;   // zero component acts as infinite
    dly = ay != 0 ? (64'd1 << 30) / ay : 64'd1 << 40;
    cx = c.pos_x >> 12;
    cy = c.pos_y >> 12;
    sx = rx < 0 ? -1 : 1;
    sy = ry < 0 ? -1 : 1;
    fx = rx < 0 ? c.pos_x[11:0] : 4096 - c.pos_x[11:0];
    fy = ry < 0 ? c.pos_y[11:0] : 4096 - c.pos_y[11:0];
    accx = (fx * dlx) >> 12;
    accy = (fy * dly) >> 12;
    side = 1'b0;
    kind = '0;
    off = 1'b1;
    // start cell is skipped; ties step along y
    for (int n = 0; n < STEP_LIMIT; n++) begin
      if (accx < accy) begin
        accx += dlx; cx += sx; side = 1'b0;
      end else begin
        accy += dly; cy += sy; side = 1'b1;
      end
      if (cx < 0 || cy < 0 || cx >= DIM || cy >= DIM) break;
      kind = map_cell(cx, cy);
      if (kind != 0) begin
        off = 1'b0;
        break;
      end
    end
    h.out_column = c.column;
    h.hit_side = side;
    h.off_map = off;
    if (off) begin
      h.wall_kind = '0;
      h.wall_color = '0;
      h.wall_distance = 16'hFFFF;
      h.draw_start = 8'(ROWS / 2);
      h.draw_end = 8'(ROWS / 2);
    end else begin
      perp_dist = side ? accy - dly : accx - dlx;
      wd = perp_dist >> 4;
      h.wall_distance = wd > 64'hFFFF ? 16'hFFFF : wd[15:0];
      height = perp_dist == 0 ? ROWS * 4 : (longint'(ROWS) << 16) / perp_dist;
      if (height > ROWS * 4) height = ROWS * 4;
      s = ROWS / 2 - longint'(height / 2);
      e = ROWS / 2 + longint'(height / 2);
      h.draw_start = s < 0 ? 8'd0 : s[7:0];
      h.draw_end = e >= ROWS ? 8'(ROWS - 1) : e[7:0];
      h.wall_kind = kind;
      case (kind)
        KIND_RED:   h.wall_color = COLOR_RED;
        KIND_GREEN: h.wall_color = COLOR_GREEN;
        KIND_BLUE:  h.wall_color = COLOR_BLUE;
        KIND_WHITE: h.wall_color = COLOR_WHITE;
        default:    h.wall_color = '0;
      endcase
    end
    return h;
  endfunction

  task automatic check_field(string name, longint unsigned want, longint unsigned got);
    if (want != got) begin
      errors++;
      $display("%0t mismatch %s: expected %0h actual %0h", $realtime, name, want, got);
    end
  endtask

  // driver: input side, fed from pending_columns, and m_tready on the output side
  always @(negedge clk) begin
    if (!rst) begin
      if (s_tvalid && !took) begin
        // hold the current transaction
      end else if (send_gap > 0) begin
        send_gap <= send_gap - 1;
        s_tvalid <= 1'b0;
      end else if (pending_columns.size() > 0) begin
        s_tdata <= pack_column(pending_columns.pop_front());
        s_tvalid <= 1'b1;
        send_gap <= pick_gap();
      end else begin
        s_tvalid <= 1'b0;
      end
      if (recv_gap > 0) begin
        recv_gap <= recv_gap - 1;
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
        recv_gap <= pick_gap();
      end
    end
  end

  // monitor: predicts on accepted columns, checks accepted results
  always @(posedge clk) begin
    wall_hit_t want, got;
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("end of test: mismatches");
      $finish;
    end
    took <= s_tvalid && s_tready && !rst;
    if (!rst && s_tvalid && s_tready)
      expected_hits.push_back(cast_column(unpack_column(s_tdata)));
    if (!rst && m_tvalid && m_tready) begin
      {got.off_map, got.wall_distance, got.wall_kind, got.hit_side, got.wall_color,
       got.draw_end, got.draw_start, got.out_column} = m_tdata[70:0];
      if (expected_hits.size() == 0) begin
        errors++;
        $display("%0t unexpected result transaction: expected none actual %0h",
                 $realtime, m_tdata);
      end else begin
        want = expected_hits.pop_front();
        hits_checked++;
        if (want.off_map) off_map_seen++;
        check_field("out_column", want.out_column, got.out_column);
        check_field("draw_start", want.draw_start, got.draw_start);
        check_field("draw_end", want.draw_end, got.draw_end);
        check_field("wall_color", want.wall_color, got.wall_color);
        check_field("hit_side", want.hit_side, got.hit_side);
        check_field("wall_kind", want.wall_kind, got.wall_kind);
        check_field("wall_distance", want.wall_distance, got.wall_distance);
        check_field("off_map", want.off_map, got.off_map);
      end
    end
  end

  task automatic write_map(logic [63:0] a, logic [63:0] b, logic [63:0] c, logic [63:0] d);
    logic [63:0] v [4];
    logic [1:0] idx [4];
    v = '{a, b, c, d};
    idx = '{REG_ROWS_A, REG_ROWS_B, REG_ROWS_C, REG_ROWS_D};
    for (int i = 0; i < 4; i++) begin
      @(negedge clk);
      cfg_we <= 1'b1;
      cfg_index <= idx[i];
      cfg_data <= v[i];
      map_shadow[idx[i]] = v[i];
    end
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // random map: closed border when border is set, interior walls with the given percentage
  task automatic random_map(int density, logic border);
    logic [63:0] m [4];
    logic [3:0] k;
    for (int y = 0; y < DIM; y++)
      for (int x = 0; x < DIM; x++) begin
        k = 4'($urandom_range(1, 15));
        if ($urandom_range(0, 99) < 70) k = 4'($urandom_range(1, 4));
        if (!(border && (x == 0 || y == 0 || x == DIM - 1 || y == DIM - 1)) &&
            $urandom_range(0, 99) >= density)
          k = '0;
        m[y >> 1][((y & 1) * 8 + x) * 4 +: 4] = k;
      end
    write_map(m[0], m[1], m[2], m[3]);
  endtask

  task automatic wait_idle();
    do @(negedge clk);
    while (pending_columns.size() > 0 || s_tvalid || expected_hits.size() > 0);
    // every accepted column has its result checked by now; idle before the next phase
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  function automatic column_req_t make_column(int col, int px, int py,
                                              int dx, int dy, int plx, int ply);
    column_req_t c;
    c.column = 9'(col); c.pos_x = 15'(px); c.pos_y = 15'(py);
    c.dir_x = 16'(dx); c.dir_y = 16'(dy); c.plane_x = 16'(plx); c.plane_y = 16'(ply);
    return c;
  endfunction

  // mostly viewer-like rays, some raw bit noise
  function automatic column_req_t random_column();
    column_req_t c;
    c = make_column($urandom_range(0, 383), $urandom_range(4096, 28671),
                    $urandom_range(4096, 28671), $urandom_range(0, 32767) - 16384,
                    $urandom_range(0, 32767) - 16384, $urandom_range(0, 21000) - 10500,
                    $urandom_range(0, 21000) - 10500);
    if ($urandom_range(0, 9) == 0) c.column = 9'($urandom_range(384, 511));
    if ($urandom_range(0, 4) == 0)
      c = unpack_column(104'({$urandom, $urandom, $urandom, $urandom}));
    return c;
  endfunction

  initial begin
    map_shadow = '{default: '0};
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed: empty map after reset, every ray leaves the map
    calm = 1'b1;
    pending_columns.push_back(make_column(0, 0, 0, 16384, 0, 0, 10813));
    pending_columns.push_back(make_column(383, 32767, 32767, -16384, 0, 0, -10813));
    pending_columns.push_back(make_column(192, 16384, 16384, 0, 0, 0, 0));
    wait_idle();

    // directed: border closed but for cell x 7, y 1, with kinds 1..5 and 15
    write_map(64'h0000_000F_4321_F4F1, 64'h1000_0003_1000_0002,
              64'h1000_0004_1000_000F, 64'h3214_F321_1000_0005);
    pending_columns.push_back(make_column(192, 4096, 8192, 16384, 0, 0, 10813));
    pending_columns.push_back(make_column(192, 4096, 8192, -16384, 0, 0, 10813));
    pending_columns.push_back(make_column(192, 20000, 4096, 0, -16384, 10813, 0));
    pending_columns.push_back(make_column(192, 16384, 16384, 0, 0, 0, 0));
    pending_columns.push_back(make_column(0, 0, 0, -32768, -32768, -32768, -32768));
    pending_columns.push_back(make_column(511, 32767, 32767, 32767, 32767, 32767, 32767));
    pending_columns.push_back(make_column(383, 12345, 23456, -32768, 32767, 32767, -32768));
    pending_columns.push_back(make_column(0, 8191, 16384, 11585, 11585, -7646, 7646));
    pending_columns.push_back(make_column(100, 28672, 28672, 0, 16384, -10813, 0));
    pending_columns.push_back(make_column(300, 6000, 26000, 16384, -16384, 0, 0));
    pending_columns.push_back(make_column(256, 20480, 12288, 0, 32767, 1, 0));
    pending_columns.push_back(make_column(192, 24576, 24576, 16384, 16384, 0, 0));
    wait_idle();

    // directed: all cells kind 15, start cell skipped and zero distance
    write_map('1, '1, '1, '1);
    pending_columns.push_back(make_column(192, 4096, 4096, 16384, 0, 0, 0));
    pending_columns.push_back(make_column(192, 4096, 4096, 0, 16384, 0, 0));
    pending_columns.push_back(make_column(192, 16384, 12288, -16384, -16384, 0, 0));
    pending_columns.push_back(make_column(10, 0, 0, -16384, -16384, 0, 0));
    wait_idle();

    // random phases over several maps, with and without idling
    for (int phase = 0; phase < 5; phase++) begin
      calm = (phase == 2);
      if (phase == 4) write_map('0, '0, '0, '0);
      else random_map(phase * 12, phase != 3);
      for (int i = 0; i < RANDOM_ITEMS / 5; i++) pending_columns.push_back(random_column());
      wait_idle();
    end

    $display("checked %0d columns (%0d left the map) over empty, full and random maps",
             hits_checked, off_map_seen);
    if (errors == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

FILE: grid_ray_caster_column.f
rtl/grc_pkg.sv
rtl/grc_div.sv
rtl/grc_datapath.sv
rtl/grc_ctrl.sv
rtl/grid_ray_caster_column.sv
rtl/grc_checker.sv
bench/grid_ray_caster_column_tb.sv
